>>> design/tsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// shared constants, types and helpers for the thumbstick radial deadzone unit
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int FULL_SCALE = 32767;
  localparam int AXIS_W     = 16;
  localparam int DZ_W       = 15;
  localparam int SENS_W     = 16;
  localparam int SQ_W       = 32;   // x*x + y*y, at most 2^31
  localparam int ROOT_W     = 16;   // floor sqrt of SQ_W bits
  localparam int NS_W       = 31;   // sens * (magc - dz)
  localparam int DEN_W      = 31;   // magr * (FULL_SCALE - dz)
  localparam int NUM_W      = 48;   // 2*prod + den
  localparam int DIV_W      = DEN_W + 1;
  localparam int QUO_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SENS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SENS = 2'd3;

  localparam logic [DZ_W-1:0]   RST_LEFT_DZ    = 15'd7849;
  localparam logic [DZ_W-1:0]   RST_RIGHT_DZ   = 15'd8689;
  localparam logic [SENS_W-1:0] RST_LEFT_SENS  = 16'd5120;
  localparam logic [SENS_W-1:0] RST_RIGHT_SENS = 16'd5120;

  // sideband carried alongside the square root
  typedef struct packed {
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic              sx;
    logic              sy;
    logic              dead;
    logic [DZ_W-1:0]   dz;
    logic [SENS_W-1:0] sens;
  } sq_side_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic sx;
    logic sy;
    logic dead;
    logic zero;
  } dv_side_t;

  // round-to-nearest quotient to a signed 16-bit delta with saturation
  function automatic logic [AXIS_W-1:0] sat_delta(input logic neg,
                                                  input logic ovf,
                                                  input logic [QUO_W-1:0] q);
    logic [AXIS_W-1:0] res;
    if (neg) begin
      if (ovf || q > 17'd32768) res = 16'h8000;
      else                      res = 16'(-q);
    end else begin
      if (ovf || q > 17'd32767) res = 16'h7fff;
      else                      res = q[AXIS_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/tsd_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module tsd_isqrt (
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [tsd_pkg::SQ_W-1:0]  s_in,
  output logic      [tsd_pkg::ROOT_W-1:0] root_out
);
  import tsd_pkg::*;

  logic [SQ_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W:0]     trial;

    if (i == 0) begin : g_first
      assign rem_in  = s_in;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = ((SQ_W+1)'(root_in) << (K + 1)) + ((SQ_W+1)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (adv) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[i]  <= SQ_W'({1'b0, rem_in} - trial);
          root_r[i] <= root_in | (ROOT_W'(1) << K);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
      end
    end
  end

  assign root_out = root_r[ROOT_W-1];

endmodule
`default_nettype wire

>>> design/tsd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_div
// pipelined restoring divider, overflow check then one quotient bit per stage
// ----------------------------------------------------------------------------
module tsd_div (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire logic [tsd_pkg::NUM_W-1:0]  num,
  input  wire logic [tsd_pkg::DIV_W-1:0]  dvs,
  output logic      [tsd_pkg::QUO_W-1:0]  quo,
  output logic                            ovf
);
  import tsd_pkg::*;

  logic [NUM_W-1:0] rem_r  [QUO_W+1];
  logic [DIV_W-1:0] dvs_r  [QUO_W+1];
  logic [QUO_W-1:0] quo_r  [QUO_W+1];
  logic             ovf_r  [QUO_W+1];

  // quotient too big for QUO_W bits
  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= {1'b0, num} >= ((NUM_W+1)'(dvs) << QUO_W);
      rem_r[0] <= num;
      dvs_r[0] <= dvs;
      quo_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_stage
    localparam int K = QUO_W - i;
    logic [NUM_W-1:0] sub;
    assign sub = NUM_W'(dvs_r[i-1]) << K;

    always_ff @(posedge clk) begin
      if (adv) begin
        dvs_r[i] <= dvs_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
        if (rem_r[i-1] >= sub) begin
          rem_r[i] <= rem_r[i-1] - sub;
          quo_r[i] <= quo_r[i-1] | (QUO_W'(1) << K);
        end else begin
          rem_r[i] <= rem_r[i-1];
          quo_r[i] <= quo_r[i-1];
        end
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule
`default_nettype wire

>>> design/thumbstick_radial_deadzone_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thumbstick_radial_deadzone_unit
// radial deadzone test and scaling of one x/y thumbstick sample per beat
// ----------------------------------------------------------------------------
// Accepts one stick sample per clock while the result register is not held
// and returns one result beat per sample, in order. The pipeline contains the
// 16-stage square root and the 18-stage dividers (one per axis); the
// whole pipeline stalls together while the result register is held, so
// in_tready follows out_tready whenever a result is waiting. Registers may
// only be written while no sample is in flight.
module thumbstick_radial_deadzone_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [31:0]                       in_tdata,  // stick_x, stick_y
  input  wire logic                              in_tuser,  // stick_sel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [31:0]                       out_tdata, // delta_x, delta_y
  output logic                                   out_tuser, // in_deadzone
  input  wire logic                              cfg_we,
  input  wire logic [tsd_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tsd_pkg::*;

  localparam int SQ_LAT = ROOT_W;
  localparam int DV_LAT = QUO_W + 1;

  logic adv;

  // configuration
  logic [DZ_W-1:0]   left_dz_r, right_dz_r;
  logic [SENS_W-1:0] left_sens_r, right_sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r    <= RST_LEFT_DZ;
      right_dz_r   <= RST_RIGHT_DZ;
      left_sens_r  <= RST_LEFT_SENS;
      right_sens_r <= RST_RIGHT_SENS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEFT_DZ:    left_dz_r    <= cfg_wdata[DZ_W-1:0];
        REG_RIGHT_DZ:   right_dz_r   <= cfg_wdata[DZ_W-1:0];
        REG_LEFT_SENS:  left_sens_r  <= cfg_wdata;
        REG_RIGHT_SENS: right_sens_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: abs values and register select
  logic [AXIS_W-1:0] in_x, in_y;
  logic              p1_v_r;
  sq_side_t          p1_r;

  assign in_x = in_tdata[15:0];
  assign in_y = in_tdata[31:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r.ax   <= in_x[15] ? AXIS_W'(-in_x) : in_x;
      p1_r.ay   <= in_y[15] ? AXIS_W'(-in_y) : in_y;
      p1_r.sx   <= in_x[15];
      p1_r.sy   <= in_y[15];
      p1_r.dead <= 1'b0;
      p1_r.dz   <= in_tuser ? right_dz_r : left_dz_r;
      p1_r.sens <= in_tuser ? right_sens_r : left_sens_r;
    end
  end

  // stage 2: squares
  logic              p2_v_r;
  sq_side_t          p2_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [2*DZ_W-1:0] dzsq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r   <= p1_r;
      sqx_r  <= SQ_W'(p1_r.ax * p1_r.ax);
      sqy_r  <= SQ_W'(p1_r.ay * p1_r.ay);
      dzsq_r <= (2*DZ_W)'(p1_r.dz * p1_r.dz);
    end
  end

  // stage 3: radius squared and deadzone test
  logic            p3_v_r;
  sq_side_t        p3_r;
  sq_side_t        p3_nxt;
  logic [SQ_W-1:0] s_r;
  logic [SQ_W-1:0] s_sum;

  assign s_sum = sqx_r + sqy_r;

  always_comb begin
    p3_nxt      = p2_r;
    p3_nxt.dead = s_sum <= SQ_W'(dzsq_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r <= p3_nxt;
      s_r  <= s_sum;
    end
  end

  // square root with matching sideband
  logic [ROOT_W-1:0] root;
  sq_side_t          sq_sd_r [SQ_LAT];
  logic              sq_v_r  [SQ_LAT];

  tsd_isqrt u_isqrt (
    .clk      (clk),
    .adv      (adv),
    .s_in     (s_r),
    .root_out (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sd_r[0] <= p3_r;
      for (int i = 1; i < SQ_LAT; i++) sq_sd_r[i] <= sq_sd_r[i-1];
    end
  end

  // stage 4: clamp and distance past the deadzone
  logic              p4_v_r;
  sq_side_t          p4_r;
  logic              p4_zero_r;
  logic [DZ_W-1:0]   diff_r, fsdz_r;
  logic [ROOT_W-1:0] root_r;
  logic [DZ_W-1:0]   magc;
  sq_side_t          sq_last;

  assign sq_last = sq_sd_r[SQ_LAT-1];
  assign magc = (root > ROOT_W'(FULL_SCALE)) ? DZ_W'(FULL_SCALE) : root[DZ_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r      <= sq_last;
      p4_zero_r <= sq_last.dead || (magc <= sq_last.dz);
      diff_r    <= magc - sq_last.dz;
      fsdz_r    <= DZ_W'(FULL_SCALE) - sq_last.dz;
      root_r    <= root;
    end
  end

  // stage 5: numerator scale and denominator
  logic             p5_v_r;
  sq_side_t         p5_r;
  logic             p5_zero_r;
  logic [NS_W-1:0]  ns_r;
  logic [DEN_W-1:0] den5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_r      <= p4_r;
      p5_zero_r <= p4_zero_r;
      ns_r      <= NS_W'(p4_r.sens * diff_r);
      den5_r    <= DEN_W'(root_r * fsdz_r);
    end
  end

  // stage 6: partial products of axis times scale
  logic             p6_v_r;
  dv_side_t         p6_r;
  logic [DEN_W-1:0] den6_r;
  logic [31:0]      plx_r, ply_r;
  logic [30:0]      phx_r, phy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_r   <= '{sx: p5_r.sx, sy: p5_r.sy, dead: p5_r.dead, zero: p5_zero_r};
      den6_r <= den5_r;
      plx_r  <= 32'(p5_r.ax * ns_r[15:0]);
      ply_r  <= 32'(p5_r.ay * ns_r[15:0]);
      phx_r  <= 31'(p5_r.ax * ns_r[NS_W-1:16]);
      phy_r  <= 31'(p5_r.ay * ns_r[NS_W-1:16]);
    end
  end

  // stage 7: rounding numerator 2*prod + den, divisor 2*den
  logic             p7_v_r;
  dv_side_t         p7_r;
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [DIV_W-1:0] dvs_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_r   <= p6_r;
      numx_r <= ((NUM_W'(plx_r) + (NUM_W'(phx_r) << 16)) << 1) + NUM_W'(den6_r);
      numy_r <= ((NUM_W'(ply_r) + (NUM_W'(phy_r) << 16)) << 1) + NUM_W'(den6_r);
      dvs_r  <= {den6_r, 1'b0};
    end
  end

  // dividers with matching sideband
  logic [QUO_W-1:0] qx, qy;
  logic             ovfx, ovfy;
  dv_side_t         dv_sd_r [DV_LAT];
  logic             dv_v_r  [DV_LAT];

  tsd_div u_div_x (
    .clk (clk),
    .adv (adv),
    .num (numx_r),
    .dvs (dvs_r),
    .quo (qx),
    .ovf (ovfx)
  );

  tsd_div u_div_y (
    .clk (clk),
    .adv (adv),
    .num (numy_r),
    .dvs (dvs_r),
    .quo (qy),
    .ovf (ovfy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sd_r[0] <= p7_r;
      for (int i = 1; i < DV_LAT; i++) dv_sd_r[i] <= dv_sd_r[i-1];
    end
  end

  // output register
  logic              out_v_r;
  logic [AXIS_W-1:0] dx_r, dy_r;
  logic              dead_r;
  dv_side_t          dv_last;

  assign dv_last = dv_sd_r[DV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dead_r <= dv_last.dead;
      dx_r   <= dv_last.zero ? '0 : sat_delta(dv_last.sx, ovfx, qx);
      dy_r   <= dv_last.zero ? '0 : sat_delta(dv_last.sy, ovfy, qy);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      p5_v_r  <= 1'b0;
      p6_v_r  <= 1'b0;
      p7_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < SQ_LAT; i++) sq_v_r[i] <= 1'b0;
      for (int i = 0; i < DV_LAT; i++) dv_v_r[i] <= 1'b0;
    end else if (adv) begin
      p1_v_r    <= in_tvalid;
      p2_v_r    <= p1_v_r;
      p3_v_r    <= p2_v_r;
      sq_v_r[0] <= p3_v_r;
      for (int i = 1; i < SQ_LAT; i++) sq_v_r[i] <= sq_v_r[i-1];
      p4_v_r    <= sq_v_r[SQ_LAT-1];
      p5_v_r    <= p4_v_r;
      p6_v_r    <= p5_v_r;
      p7_v_r    <= p6_v_r;
      dv_v_r[0] <= p7_v_r;
      for (int i = 1; i < DV_LAT; i++) dv_v_r[i] <= dv_v_r[i-1];
      out_v_r   <= dv_v_r[DV_LAT-1];
    end
  end

  assign adv        = !out_v_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {dy_r, dx_r};
  assign out_tuser  = dead_r;

  // a deadzone result always carries zero deltas
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("deadzone result with non-zero delta");

  // an accepted sample enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> p1_v_r)
    else $error("accepted sample lost at pipeline entry");

  // a stall freezes the valid bits at the divider output and at stage 4
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_v_r[DV_LAT-1]) && $stable(p4_v_r))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
